>>> hdl/sapd_pkg.sv
// Shared types and codes for the prefix-doubling suffix array builder.
`timescale 1ns / 1ps
package sapd_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [8:0] symbol;
    logic       last;
    logic [9:0] rank;
  } in_item_t;

  typedef struct packed {
    logic [9:0] position;
    logic       rank_invalid;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic sort;
    logic read;
  } eng_req_t;

endpackage

>>> hdl/sapd_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module sapd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/sapd_engine.sv
// Sort sequencer: owns the text, bucket head, position, rank, count, mark and work memories.
`timescale 1ns / 1ps
module sapd_engine import sapd_pkg::*; #(
  parameter int MAX_LEN = 1024,
  parameter int ALPHABET_SIZE = 257,
  localparam int AW = $clog2(MAX_LEN),
  localparam int LW = $clog2(MAX_LEN + 1),
  localparam int HW = LW + 1,
  localparam int SW = $clog2(ALPHABET_SIZE),
  localparam int KW = $clog2(ALPHABET_SIZE + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  eng_req_t      req,
  input  logic [AW-1:0] req_addr,
  input  logic [SW-1:0] req_sym,
  input  logic [LW-1:0] req_len,
  output logic          busy,
  output logic [AW-1:0] sp_rdata
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_HZ, ST_CNT_A, ST_CNT_B, ST_CNT_C, ST_PS_A, ST_PS_B,
    ST_SC_A, ST_SC_B, ST_SC_C, ST_MK_A, ST_MK_B, ST_MK_C, ST_AR_A, ST_AR_B,
    ST_TL_A, ST_TL_B, ST_UP_A, ST_UP_B, ST_UP_C, ST_SH_A, ST_SH_B,
    ST_RF_A, ST_RF_B, ST_RF_C
  } state_t;

  state_t        state_r;
  logic [LW-1:0] c_r, n_r, run_r, prev_key_r;
  logic [KW-1:0] k_r;
  logic [HW-1:0] h_r;
  logic [AW-1:0] head_r, d_r, r_r;
  logic [SW-1:0] sym_r, prev_sym_r;
  logic          tv_r, m_r, rnd_r, first_r;

  logic          tx_we, tx_re;
  logic [AW-1:0] tx_wa, tx_ra;
  logic [SW-1:0] tx_wd, tx_rd;
  logic          hd_we, hd_re;
  logic [SW-1:0] hd_wa, hd_ra;
  logic [LW-1:0] hd_wd, hd_rd;
  logic          sp_we, sp_re;
  logic [AW-1:0] sp_wa, sp_ra, sp_wd, sp_rd;
  logic          mk_we, mk_re;
  logic [AW-1:0] mk_wa, mk_ra;
  logic          mk_wd, mk_rd;
  logic          rk_we, rk_re;
  logic [AW-1:0] rk_wa, rk_ra, rk_wd, rk_rd;
  logic          ct_we, ct_re;
  logic [AW-1:0] ct_wa, ct_ra;
  logic [LW-1:0] ct_wd, ct_rd;
  logic          wk_we, wk_re;
  logic [AW-1:0] wk_wa, wk_ra, wk_wd, wk_rd;

  logic [LW-1:0] c_nx;
  logic [HW-1:0] h_nx, t_sum, tail_d, sp_ext;
  logic [LW:0]   slot;
  logic [LW-1:0] key;
  logic          mark_first, mark_ref, ar_m;
  logic [AW-1:0] ar_pos, ar_hd;

  sapd_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_text (
    .clk(clk), .we(tx_we), .waddr(tx_wa), .wdata(tx_wd),
    .re(tx_re), .raddr(tx_ra), .rdata(tx_rd));
  sapd_ram #(.WIDTH(LW), .DEPTH(ALPHABET_SIZE)) u_heads (
    .clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd),
    .re(hd_re), .raddr(hd_ra), .rdata(hd_rd));
  sapd_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_sorted (
    .clk(clk), .we(sp_we), .waddr(sp_wa), .wdata(sp_wd),
    .re(sp_re), .raddr(sp_ra), .rdata(sp_rd));
  sapd_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_marks (
    .clk(clk), .we(mk_we), .waddr(mk_wa), .wdata(mk_wd),
    .re(mk_re), .raddr(mk_ra), .rdata(mk_rd));
  sapd_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_ranks (
    .clk(clk), .we(rk_we), .waddr(rk_wa), .wdata(rk_wd),
    .re(rk_re), .raddr(rk_ra), .rdata(rk_rd));
  sapd_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_counts (
    .clk(clk), .we(ct_we), .waddr(ct_wa), .wdata(ct_wd),
    .re(ct_re), .raddr(ct_ra), .rdata(ct_rd));
  sapd_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_work (
    .clk(clk), .we(wk_we), .waddr(wk_wa), .wdata(wk_wd),
    .re(wk_re), .raddr(wk_ra), .rdata(wk_rd));

  assign busy     = (state_r != ST_IDLE);
  assign sp_rdata = sp_rd;

  always_comb begin
    c_nx       = c_r + LW'(1);
    h_nx       = rnd_r ? (h_r << 1) : h_r;
    t_sum      = HW'(wk_rd) + h_r;
    tail_d     = HW'(n_r) - h_nx + HW'(1);
    sp_ext     = HW'(sp_rd);
    slot       = (LW + 1)'(r_r) + (LW + 1)'(ct_rd);
    key        = tv_r ? (LW'(rk_rd) + LW'(1)) : '0;
    mark_first = (c_r == '0) || (tx_rd != prev_sym_r);
    mark_ref   = m_r || ((c_r != '0) && (key != prev_key_r));
    ar_m       = mk_rd;
    ar_pos     = rnd_r ? wk_rd : sp_rd;
    ar_hd      = ar_m ? c_r[AW-1:0] : head_r;
  end

  always_comb begin
    tx_we = 1'b0; tx_wa = req_addr; tx_wd = req_sym; tx_re = 1'b0; tx_ra = c_r[AW-1:0];
    hd_we = 1'b0; hd_wa = sym_r; hd_wd = hd_rd + LW'(1); hd_re = 1'b0; hd_ra = tx_rd;
    sp_we = 1'b0; sp_wa = c_r[AW-1:0]; sp_wd = wk_rd; sp_re = 1'b0; sp_ra = c_r[AW-1:0];
    mk_we = 1'b0; mk_wa = c_r[AW-1:0]; mk_wd = mark_ref; mk_re = 1'b0;
    mk_ra = c_r[AW-1:0];
    rk_we = 1'b0; rk_wa = ar_pos; rk_wd = ar_hd; rk_re = 1'b0; rk_ra = d_r;
    ct_we = 1'b0; ct_wa = c_r[AW-1:0]; ct_wd = '0; ct_re = 1'b0; ct_ra = rk_rd;
    wk_we = 1'b0; wk_wa = rk_rd; wk_wd = d_r; wk_re = 1'b0; wk_ra = c_r[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        tx_we = req.load;
        sp_re = req.read;
        sp_ra = req_addr;
      end
      ST_HZ: begin
        hd_we = 1'b1;
        hd_wa = k_r[SW-1:0];
        hd_wd = '0;
      end
      ST_CNT_A, ST_SC_A: tx_re = 1'b1;
      ST_CNT_B, ST_SC_B: hd_re = 1'b1;
      ST_CNT_C: hd_we = 1'b1;
      ST_PS_A: begin
        hd_re = 1'b1;
        hd_ra = k_r[SW-1:0];
      end
      ST_PS_B: begin
        hd_we = 1'b1;
        hd_wa = k_r[SW-1:0];
        hd_wd = run_r;
      end
      ST_SC_C: begin
        hd_we = 1'b1;
        sp_we = 1'b1;
        sp_wa = hd_rd[AW-1:0];
        sp_wd = c_r[AW-1:0];
      end
      ST_MK_A, ST_SH_A: sp_re = 1'b1;
      ST_MK_B: begin
        tx_re = 1'b1;
        tx_ra = sp_rd;
      end
      ST_MK_C: begin
        mk_we = 1'b1;
        mk_wd = mark_first;
      end
      ST_AR_A: begin
        mk_re = 1'b1;
        sp_re = !rnd_r;
        wk_re = rnd_r;
      end
      ST_AR_B: begin
        rk_we = 1'b1;
        ct_we = 1'b1;
        sp_we = rnd_r;
      end
      ST_TL_A, ST_UP_A: rk_re = 1'b1;
      ST_TL_B: wk_we = 1'b1;
      ST_UP_B: ct_re = 1'b1;
      ST_UP_C: begin
        ct_we = 1'b1;
        ct_wa = r_r;
        ct_wd = ct_rd + LW'(1);
        wk_we = (slot < (LW + 1)'(n_r));
        wk_wa = slot[AW-1:0];
      end
      ST_SH_B: ;
      ST_RF_A: begin
        wk_re = 1'b1;
        mk_re = 1'b1;
      end
      ST_RF_B: begin
        rk_re = (t_sum < HW'(n_r));
        rk_ra = t_sum[AW-1:0];
      end
      ST_RF_C: mk_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      c_r     <= '0;
      k_r     <= '0;
      h_r     <= '0;
      n_r     <= '0;
      rnd_r   <= 1'b0;
      first_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (req.sort && (req_len != '0)) begin
            n_r     <= req_len;
            k_r     <= '0;
            h_r     <= HW'(1);
            rnd_r   <= 1'b0;
            state_r <= ST_HZ;
          end
        end
        ST_HZ: begin
          k_r <= k_r + KW'(1);
          if (k_r == KW'(ALPHABET_SIZE - 1)) begin
            c_r     <= '0;
            state_r <= ST_CNT_A;
          end
        end
        ST_CNT_A: state_r <= ST_CNT_B;
        ST_CNT_B: begin
          sym_r   <= tx_rd;
          state_r <= ST_CNT_C;
        end
        ST_CNT_C: begin
          c_r <= c_nx;
          if (c_nx == n_r) begin
            k_r     <= '0;
            run_r   <= '0;
            state_r <= ST_PS_A;
          end else begin
            state_r <= ST_CNT_A;
          end
        end
        ST_PS_A: state_r <= ST_PS_B;
        ST_PS_B: begin
          run_r <= run_r + hd_rd;
          k_r   <= k_r + KW'(1);
          if (k_r == KW'(ALPHABET_SIZE - 1)) begin
            c_r     <= '0;
            state_r <= ST_SC_A;
          end else begin
            state_r <= ST_PS_A;
          end
        end
        ST_SC_A: state_r <= ST_SC_B;
        ST_SC_B: begin
          sym_r   <= tx_rd;
          state_r <= ST_SC_C;
        end
        ST_SC_C: begin
          c_r <= c_nx;
          if (c_nx == n_r) begin
            c_r     <= '0;
            state_r <= ST_MK_A;
          end else begin
            state_r <= ST_SC_A;
          end
        end
        ST_MK_A: state_r <= ST_MK_B;
        ST_MK_B: state_r <= ST_MK_C;
        ST_MK_C: begin
          prev_sym_r <= tx_rd;
          c_r        <= c_nx;
          if (c_nx == n_r) begin
            c_r     <= '0;
            head_r  <= '0;
            state_r <= ST_AR_A;
          end else begin
            state_r <= ST_MK_A;
          end
        end
        ST_AR_A: state_r <= ST_AR_B;
        ST_AR_B: begin
          head_r <= ar_hd;
          c_r    <= c_nx;
          if (c_nx != n_r) begin
            state_r <= ST_AR_A;
          end else begin
            h_r <= h_nx;
            c_r <= '0;
            if (h_nx >= HW'(n_r)) begin
              state_r <= ST_IDLE;
            end else if (tail_d == HW'(n_r)) begin
              d_r     <= AW'(HW'(n_r) - h_nx);
              first_r <= 1'b1;
              state_r <= ST_UP_A;
            end else begin
              d_r     <= tail_d[AW-1:0];
              state_r <= ST_TL_A;
            end
          end
        end
        ST_TL_A: state_r <= ST_TL_B;
        ST_TL_B: begin
          d_r <= d_r + AW'(1);
          if (LW'(d_r) + LW'(1) == n_r) begin
            d_r     <= AW'(HW'(n_r) - h_r);
            first_r <= 1'b1;
            state_r <= ST_UP_A;
          end else begin
            state_r <= ST_TL_A;
          end
        end
        ST_UP_A: state_r <= ST_UP_B;
        ST_UP_B: begin
          r_r     <= rk_rd;
          state_r <= ST_UP_C;
        end
        ST_UP_C: begin
          if (first_r) begin
            first_r <= 1'b0;
            c_r     <= '0;
            state_r <= ST_SH_A;
          end else begin
            c_r <= c_nx;
            if (c_nx == n_r) begin
              c_r     <= '0;
              state_r <= ST_RF_A;
            end else begin
              state_r <= ST_SH_A;
            end
          end
        end
        ST_SH_A: state_r <= ST_SH_B;
        ST_SH_B: begin
          if (sp_ext >= h_r) begin
            d_r     <= AW'(sp_ext - h_r);
            state_r <= ST_UP_A;
          end else begin
            c_r <= c_nx;
            if (c_nx == n_r) begin
              c_r     <= '0;
              state_r <= ST_RF_A;
            end else begin
              state_r <= ST_SH_A;
            end
          end
        end
        ST_RF_A: state_r <= ST_RF_B;
        ST_RF_B: begin
          tv_r    <= (t_sum < HW'(n_r));
          m_r     <= mk_rd;
          state_r <= ST_RF_C;
        end
        ST_RF_C: begin
          prev_key_r <= key;
          c_r        <= c_nx;
          if (c_nx == n_r) begin
            c_r     <= '0;
            head_r  <= '0;
            rnd_r   <= 1'b1;
            state_r <= ST_AR_A;
          end else begin
            state_r <= ST_RF_A;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/suffix_array_prefix_doubling.sv
// Top level: command handshake, block length tracking and result register.
// A read is first marked pending; its result is then registered once the result register is free.
// A sort first buckets the symbols, then runs ceil(log2(n)) doubling rounds, the sequencer
// making one memory access pass per element in each phase; no item is taken meanwhile.
// Synchronous active-low reset empties the block and the result register.
`timescale 1ns / 1ps
module suffix_array_prefix_doubling import sapd_pkg::*; #(
  parameter int MAX_LEN = 1024,
  parameter int ALPHABET_SIZE = 257
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW  = $clog2(MAX_LEN);
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int SW  = $clog2(ALPHABET_SIZE);
  localparam int CW  = (LW > 10) ? LW : 10;
  localparam int SCW = (SW > 9) ? SW : 9;

  logic [LW-1:0] len_r, base, len_nxt;
  logic          sorted_r, rd_pend_r, rd_inv_r, out_valid_r;
  out_item_t     out_data_r;
  logic          in_acc, is_load, full, rd_inv, busy;
  logic [CW-1:0] rank_w;
  logic [SW-1:0] sym_sat;
  logic [AW-1:0] sp_rdata, req_addr;
  eng_req_t      req;

  assign in_ready = !busy && !rd_pend_r;
  assign in_acc   = in_valid && in_ready;
  assign is_load  = (in_data.cmd == CMD_LOAD);

  always_comb begin
    base    = sorted_r ? '0 : len_r;
    full    = (LW'(base) == LW'(MAX_LEN));
    len_nxt = full ? base : (base + LW'(1));
    rank_w  = CW'(in_data.rank);
    rd_inv  = !sorted_r || (rank_w >= CW'(len_r));
    if (SCW'(in_data.symbol) >= SCW'(ALPHABET_SIZE)) begin
      sym_sat = SW'(ALPHABET_SIZE - 1);
    end else begin
      sym_sat = SW'(in_data.symbol);
    end
    req_addr  = is_load ? base[AW-1:0] : rank_w[AW-1:0];
    req.load  = in_acc && is_load && !full;
    req.sort  = in_acc && is_load && in_data.last;
    req.read  = in_acc && !is_load && !rd_inv;
  end

  sapd_engine #(.MAX_LEN(MAX_LEN), .ALPHABET_SIZE(ALPHABET_SIZE)) u_engine (
    .clk(clk), .rst_n(rst_n), .req(req), .req_addr(req_addr), .req_sym(sym_sat),
    .req_len(len_nxt), .busy(busy), .sp_rdata(sp_rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      sorted_r    <= 1'b0;
      rd_pend_r   <= 1'b0;
      rd_inv_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc && is_load) begin
        len_r    <= len_nxt;
        sorted_r <= in_data.last;
      end
      if (in_acc && !is_load) begin
        rd_pend_r <= 1'b1;
        rd_inv_r  <= rd_inv;
      end
      if (rd_pend_r && (!out_valid_r || out_ready)) begin
        rd_pend_r   <= 1'b0;
        out_valid_r <= 1'b1;
        out_data_r.rank_invalid <= rd_inv_r;
        out_data_r.position     <= rd_inv_r ? 10'd0 : 10'(sp_rdata);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_read_during_sort: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_pend_r && busy))
    else $error("read pending while the sequencer is sorting");

  a_sort_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_load && in_data.last && (len_nxt > LW'(1))) |=> busy)
    else $error("sort did not start after the last symbol");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.rank_invalid) |-> (out_data.position == 10'd0))
    else $error("invalid result carries a position");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_LEN))
    else $error("block length beyond capacity");

endmodule
